>>> rtl/fbde_pkg.sv
// shared constants, types and codes for the framebuffer draw engine
`default_nettype none

package fbde_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int X_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CRD_W      = (X_W > Y_W) ? X_W : Y_W;

    localparam int DIM_W   = 7;
    localparam int COL_W   = 32;
    localparam int POS_W   = 16;
    localparam int RAD_W   = 12;
    localparam int OUT_W   = 24;
    localparam int OP_W    = 3;
    localparam int D_W     = RAD_W + 2;
    localparam int SQ_W    = 2 * RAD_W + 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [COL_W-1:0] LOW24_MASK = 32'h00FF_FFFF;
    localparam logic [DIM_W-1:0] DIM_RESET  = 7'd64;

    localparam logic [OP_W-1:0] OP_SET    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd2;
    localparam logic [OP_W-1:0] OP_RECT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CIRCLE = 3'd4;

    localparam logic KIND_GET  = 1'b0;
    localparam logic KIND_INIT = 1'b1;

    localparam logic REG_FRAME_W = 1'b0;
    localparam logic REG_FRAME_H = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  data;
    } ram_wr_t;

endpackage

`default_nettype wire

>>> rtl/fbde_ram.sv
// frame store: one write port, one registered read port
`default_nettype none

module fbde_ram (
    input  wire logic                          clk,
    input  wire fbde_pkg::ram_wr_t             wr,
    input  wire logic [fbde_pkg::ADDR_W-1:0]   rd_addr,
    output logic      [fbde_pkg::COL_W-1:0]    rd_data
);

    logic [fbde_pkg::COL_W-1:0] mem [0:fbde_pkg::DEPTH-1];
    logic [fbde_pkg::COL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/fbde_regs.sv
// apb configuration registers and effective frame size
`default_nettype none

module fbde_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fbde_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [fbde_pkg::PDATA_W-1:0]   pwdata,
    output logic      [fbde_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output fbde_pkg::cfg_t                      cfg
);

    logic [fbde_pkg::DIM_W-1:0] frame_w_reg;
    logic [fbde_pkg::DIM_W-1:0] frame_h_reg;
    logic                       reg_idx;
    logic                       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fbde_pkg::PADDR_W-1];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg <= fbde_pkg::DIM_RESET;
            frame_h_reg <= fbde_pkg::DIM_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                fbde_pkg::REG_FRAME_W: frame_w_reg <= pwdata[fbde_pkg::DIM_W-1:0];
                fbde_pkg::REG_FRAME_H: frame_h_reg <= pwdata[fbde_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            fbde_pkg::REG_FRAME_W: prdata[fbde_pkg::DIM_W-1:0] = frame_w_reg;
            fbde_pkg::REG_FRAME_H: prdata[fbde_pkg::DIM_W-1:0] = frame_h_reg;
            default: ;
        endcase
    end

    // saturate to the store size
    always_comb
    begin
        cfg.eff_w = (32'(frame_w_reg) > fbde_pkg::MAX_WIDTH) ?
                    fbde_pkg::DIM_W'(fbde_pkg::MAX_WIDTH) : frame_w_reg;
        cfg.eff_h = (32'(frame_h_reg) > fbde_pkg::MAX_HEIGHT) ?
                    fbde_pkg::DIM_W'(fbde_pkg::MAX_HEIGHT) : frame_h_reg;
    end

endmodule

`default_nettype wire

>>> rtl/fbde_engine.sv
// command sequencer: clear pass, pixel ops, rect and circle scan
`default_nettype none

module fbde_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fbde_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fbde_pkg::OP_W-1:0]     op,
    input  wire logic [fbde_pkg::POS_W-1:0]    pos_x,
    input  wire logic [fbde_pkg::POS_W-1:0]    pos_y,
    input  wire logic [fbde_pkg::COL_W-1:0]    pixel_colour,
    input  wire logic [fbde_pkg::COL_W-1:0]    reference_colour,
    input  wire logic [fbde_pkg::POS_W-1:0]    rect_width,
    input  wire logic [fbde_pkg::POS_W-1:0]    rect_height,
    input  wire logic [fbde_pkg::RAD_W-1:0]    radius,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               result_kind,
    output logic      [fbde_pkg::OUT_W-1:0]    read_colour,
    output logic                               init_written,
    output fbde_pkg::ram_wr_t                  ram_wr,
    output logic      [fbde_pkg::ADDR_W-1:0]   ram_rd_addr,
    input  wire logic [fbde_pkg::COL_W-1:0]    ram_rd_data
);

    localparam int SPAN_W = fbde_pkg::POS_W + 2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_BASE,
        S_READ,
        S_RESP,
        S_SQR,
        S_SQY,
        S_SQX,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic                       ok;
        logic [fbde_pkg::CRD_W-1:0] first;
        logic [fbde_pkg::CRD_W-1:0] last;
    } span_t;

    function automatic span_t clip_span(
        input logic [fbde_pkg::POS_W-1:0] pos,
        input logic [fbde_pkg::POS_W-1:0] len,
        input logic [fbde_pkg::RAD_W-1:0] rad,
        input logic                       circ,
        input logic [fbde_pkg::DIM_W-1:0] lim
    );
        logic signed [SPAN_W-1:0] p;
        logic signed [SPAN_W-1:0] rr;
        logic signed [SPAN_W-1:0] l;
        logic signed [SPAN_W-1:0] lm;
        logic signed [SPAN_W-1:0] lo;
        logic signed [SPAN_W-1:0] hi;
        logic signed [SPAN_W-1:0] hi_m1;
        span_t                    s;
        p     = $signed({2'b00, pos});
        rr    = $signed({{(SPAN_W - fbde_pkg::RAD_W){1'b0}}, rad});
        l     = $signed({2'b00, len});
        lm    = $signed({{(SPAN_W - fbde_pkg::DIM_W){1'b0}}, lim});
        lo    = circ ? (p - rr) : p;
        hi    = circ ? (p + rr) : (p + l);
        if (lo < 0)
        begin
            lo = '0;
        end
        if (hi > lm)
        begin
            hi = lm;
        end
        hi_m1   = hi - SPAN_W'(1);
        s.ok    = (lo < hi);
        s.first = lo[fbde_pkg::CRD_W-1:0];
        s.last  = hi_m1[fbde_pkg::CRD_W-1:0];
        return s;
    endfunction

    state_t                        state_reg, state_next;
    logic [fbde_pkg::ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          kind_reg, kind_next;
    logic [fbde_pkg::OUT_W-1:0]    rcol_reg, rcol_next;
    logic                          iw_reg, iw_next;

    logic [fbde_pkg::OP_W-1:0]     cmd_op_reg, cmd_op_next;
    logic [fbde_pkg::POS_W-1:0]    cmd_px_reg, cmd_px_next;
    logic [fbde_pkg::POS_W-1:0]    cmd_py_reg, cmd_py_next;
    logic [fbde_pkg::COL_W-1:0]    cmd_col_reg, cmd_col_next;
    logic [fbde_pkg::COL_W-1:0]    cmd_ref_reg, cmd_ref_next;
    logic [fbde_pkg::POS_W-1:0]    cmd_rw_reg, cmd_rw_next;
    logic [fbde_pkg::POS_W-1:0]    cmd_rh_reg, cmd_rh_next;
    logic [fbde_pkg::RAD_W-1:0]    cmd_r_reg, cmd_r_next;

    logic [fbde_pkg::X_W-1:0]      x_reg, x_next;
    logic [fbde_pkg::X_W-1:0]      x_first_reg, x_first_next;
    logic [fbde_pkg::X_W-1:0]      x_last_reg, x_last_next;
    logic [fbde_pkg::Y_W-1:0]      y_reg, y_next;
    logic [fbde_pkg::Y_W-1:0]      y_last_reg, y_last_next;
    logic                          inside_reg, inside_next;
    logic [fbde_pkg::ADDR_W-1:0]   row_base_reg, row_base_next;
    logic signed [fbde_pkg::D_W-1:0] dx_reg, dx_next;
    logic signed [fbde_pkg::D_W-1:0] dx0_reg, dx0_next;
    logic signed [fbde_pkg::D_W-1:0] dy_reg, dy_next;
    logic [fbde_pkg::SQ_W-1:0]     r2_reg, r2_next;
    logic [fbde_pkg::SQ_W-1:0]     dx2_reg, dx2_next;
    logic [fbde_pkg::SQ_W-1:0]     dx0sq_reg, dx0sq_next;
    logic [fbde_pkg::SQ_W-1:0]     dy2_reg, dy2_next;

    span_t                         xs, ys;
    logic                          is_circ;
    logic [fbde_pkg::POS_W-1:0]    x_len, y_len;
    logic [SPAN_W-1:0]             dx_full, dy_full;
    logic [fbde_pkg::ADDR_W-1:0]   pix_addr;
    logic [fbde_pkg::D_W-1:0]      sq_src;
    logic [fbde_pkg::D_W-1:0]      sq_abs;
    logic [fbde_pkg::RAD_W-1:0]    sq_in;
    logic [fbde_pkg::SQ_W-1:0]     sq_prod;
    logic [fbde_pkg::SQ_W:0]       dist2;
    logic                          hit;
    logic [fbde_pkg::SQ_W:0]       dx_step, dy_step;
    logic [fbde_pkg::SQ_W:0]       dx2_inc, dy2_inc;
    logic                          init_ok;

    // span decode from the captured command
    always_comb
    begin
        is_circ = (cmd_op_reg == fbde_pkg::OP_CIRCLE);
        x_len   = (cmd_op_reg == fbde_pkg::OP_RECT) ? cmd_rw_reg : fbde_pkg::POS_W'(1);
        y_len   = (cmd_op_reg == fbde_pkg::OP_RECT) ? cmd_rh_reg : fbde_pkg::POS_W'(1);
        xs      = clip_span(cmd_px_reg, x_len, cmd_r_reg, is_circ, cfg.eff_w);
        ys      = clip_span(cmd_py_reg, y_len, cmd_r_reg, is_circ, cfg.eff_h);
        dx_full = {{(SPAN_W - fbde_pkg::CRD_W){1'b0}}, xs.first} - {2'b00, cmd_px_reg};
        dy_full = {{(SPAN_W - fbde_pkg::CRD_W){1'b0}}, ys.first} - {2'b00, cmd_py_reg};
    end

    // shared squarer for circle setup
    always_comb
    begin
        case (state_reg)
            S_SQY:   sq_src = dy_reg;
            default: sq_src = dx_reg;
        endcase
        sq_abs = sq_src[fbde_pkg::D_W-1] ? (~sq_src + fbde_pkg::D_W'(1)) : sq_src;
        sq_in  = (state_reg == S_SQR) ? cmd_r_reg : sq_abs[fbde_pkg::RAD_W-1:0];
        sq_prod = fbde_pkg::SQ_W'({{fbde_pkg::RAD_W{1'b0}}, sq_in} *
                                  {{fbde_pkg::RAD_W{1'b0}}, sq_in});
    end

    // incremental distance terms
    always_comb
    begin
        pix_addr = row_base_reg + fbde_pkg::ADDR_W'(x_reg);
        dist2    = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        hit      = (dist2 <= {1'b0, r2_reg});
        dx_step  = {{(fbde_pkg::SQ_W - fbde_pkg::D_W){dx_reg[fbde_pkg::D_W-1]}}, dx_reg, 1'b1};
        dy_step  = {{(fbde_pkg::SQ_W - fbde_pkg::D_W){dy_reg[fbde_pkg::D_W-1]}}, dy_reg, 1'b1};
        dx2_inc  = {1'b0, dx2_reg} + dx_step;
        dy2_inc  = {1'b0, dy2_reg} + dy_step;
        init_ok  = inside_reg && ((ram_rd_data & fbde_pkg::LOW24_MASK) == cmd_ref_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        rcol_next      = rcol_reg;
        iw_next        = iw_reg;
        cmd_op_next    = cmd_op_reg;
        cmd_px_next    = cmd_px_reg;
        cmd_py_next    = cmd_py_reg;
        cmd_col_next   = cmd_col_reg;
        cmd_ref_next   = cmd_ref_reg;
        cmd_rw_next    = cmd_rw_reg;
        cmd_rh_next    = cmd_rh_reg;
        cmd_r_next     = cmd_r_reg;
        x_next         = x_reg;
        x_first_next   = x_first_reg;
        x_last_next    = x_last_reg;
        y_next         = y_reg;
        y_last_next    = y_last_reg;
        inside_next    = inside_reg;
        row_base_next  = row_base_reg;
        dx_next        = dx_reg;
        dx0_next       = dx0_reg;
        dy_next        = dy_reg;
        r2_next        = r2_reg;
        dx2_next       = dx2_reg;
        dx0sq_next     = dx0sq_reg;
        dy2_next       = dy2_reg;
        ram_wr         = '0;
        ram_rd_addr    = pix_addr;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr.en     = 1'b1;
                ram_wr.addr   = clr_addr_reg;
                ram_wr.data   = '0;
                clr_addr_next = clr_addr_reg + fbde_pkg::ADDR_W'(1);
                if (clr_addr_reg == fbde_pkg::ADDR_W'(fbde_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_op_next  = op;
                    cmd_px_next  = pos_x;
                    cmd_py_next  = pos_y;
                    cmd_col_next = pixel_colour;
                    cmd_ref_next = reference_colour;
                    cmd_rw_next  = rect_width;
                    cmd_rh_next  = rect_height;
                    cmd_r_next   = radius;
                    state_next   = S_SETUP;
                end
            end
            S_SETUP:
            begin
                x_next       = xs.first[fbde_pkg::X_W-1:0];
                x_first_next = xs.first[fbde_pkg::X_W-1:0];
                x_last_next  = xs.last[fbde_pkg::X_W-1:0];
                y_next       = ys.first[fbde_pkg::Y_W-1:0];
                y_last_next  = ys.last[fbde_pkg::Y_W-1:0];
                dx_next      = dx_full[fbde_pkg::D_W-1:0];
                dx0_next     = dx_full[fbde_pkg::D_W-1:0];
                dy_next      = dy_full[fbde_pkg::D_W-1:0];
                inside_next  = xs.ok && ys.ok;
                case (cmd_op_reg) inside
                    fbde_pkg::OP_SET, fbde_pkg::OP_RECT, fbde_pkg::OP_CIRCLE:
                        state_next = (xs.ok && ys.ok) ? S_BASE : S_IDLE;
                    fbde_pkg::OP_GET, fbde_pkg::OP_INIT:
                        state_next = (xs.ok && ys.ok) ? S_BASE : S_RESP;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_BASE:
            begin
                row_base_next = fbde_pkg::ADDR_W'(
                    {{fbde_pkg::DIM_W{1'b0}}, y_reg} * {{fbde_pkg::Y_W{1'b0}}, cfg.eff_w});
                case (cmd_op_reg) inside
                    fbde_pkg::OP_GET, fbde_pkg::OP_INIT: state_next = S_READ;
                    fbde_pkg::OP_CIRCLE:                 state_next = S_SQR;
                    default:                             state_next = S_SCAN;
                endcase
            end
            S_READ:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_op_reg == fbde_pkg::OP_INIT)
                    begin
                        kind_next   = fbde_pkg::KIND_INIT;
                        rcol_next   = '0;
                        iw_next     = init_ok;
                        ram_wr.en   = init_ok;
                        ram_wr.addr = pix_addr;
                        ram_wr.data = cmd_col_reg;
                    end
                    else
                    begin
                        kind_next = fbde_pkg::KIND_GET;
                        rcol_next = inside_reg ? ram_rd_data[fbde_pkg::OUT_W-1:0] : '0;
                        iw_next   = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_SQR:
            begin
                r2_next    = sq_prod;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                dy2_next   = sq_prod;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                dx2_next   = sq_prod;
                dx0sq_next = sq_prod;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ram_wr.en   = !is_circ || hit;
                ram_wr.addr = pix_addr;
                ram_wr.data = cmd_col_reg;
                if (x_reg == x_last_reg)
                begin
                    if (y_reg == y_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        y_next        = y_reg + fbde_pkg::Y_W'(1);
                        row_base_next = row_base_reg + fbde_pkg::ADDR_W'(cfg.eff_w);
                        x_next        = x_first_reg;
                        dx_next       = dx0_reg;
                        dx2_next      = dx0sq_reg;
                        dy_next       = dy_reg + fbde_pkg::D_W'(1);
                        dy2_next      = dy2_inc[fbde_pkg::SQ_W-1:0];
                    end
                end
                else
                begin
                    x_next   = x_reg + fbde_pkg::X_W'(1);
                    dx_next  = dx_reg + fbde_pkg::D_W'(1);
                    dx2_next = dx2_inc[fbde_pkg::SQ_W-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= fbde_pkg::KIND_GET;
            rcol_reg      <= '0;
            iw_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            rcol_reg      <= rcol_next;
            iw_reg        <= iw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_op_reg   <= cmd_op_next;
        cmd_px_reg   <= cmd_px_next;
        cmd_py_reg   <= cmd_py_next;
        cmd_col_reg  <= cmd_col_next;
        cmd_ref_reg  <= cmd_ref_next;
        cmd_rw_reg   <= cmd_rw_next;
        cmd_rh_reg   <= cmd_rh_next;
        cmd_r_reg    <= cmd_r_next;
        x_reg        <= x_next;
        x_first_reg  <= x_first_next;
        x_last_reg   <= x_last_next;
        y_reg        <= y_next;
        y_last_reg   <= y_last_next;
        inside_reg   <= inside_next;
        row_base_reg <= row_base_next;
        dx_reg       <= dx_next;
        dx0_reg      <= dx0_next;
        dy_reg       <= dy_next;
        r2_reg       <= r2_next;
        dx2_reg      <= dx2_next;
        dx0sq_reg    <= dx0sq_next;
        dy2_reg      <= dy2_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign read_colour  = rcol_reg;
    assign init_written = iw_reg;

endmodule

`default_nettype wire

>>> rtl/framebuffer_draw_engine.sv
// top level: framebuffer draw engine with apb configuration
// get and init: setup, base, read and resp states; resp waits while a result is stalled
// set and rect: setup and base states, then a scan state writes the clipped pixels
// circle: setup, base, squaring, then a scan of the clipped box (one store write port)
// off-frame set, empty fills, unused opcodes: setup only; off-frame get and init: setup, resp
// reset: a clearing pass zeroes every store word in turn, in_ready low meanwhile
`default_nettype none

module framebuffer_draw_engine (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fbde_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [fbde_pkg::PDATA_W-1:0]   pwdata,
    output logic      [fbde_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [fbde_pkg::OP_W-1:0]      op,
    input  wire logic [fbde_pkg::POS_W-1:0]     pos_x,
    input  wire logic [fbde_pkg::POS_W-1:0]     pos_y,
    input  wire logic [fbde_pkg::COL_W-1:0]     pixel_colour,
    input  wire logic [fbde_pkg::COL_W-1:0]     reference_colour,
    input  wire logic [fbde_pkg::POS_W-1:0]     rect_width,
    input  wire logic [fbde_pkg::POS_W-1:0]     rect_height,
    input  wire logic [fbde_pkg::RAD_W-1:0]     radius,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                result_kind,
    output logic      [fbde_pkg::OUT_W-1:0]     read_colour,
    output logic                                init_written
);

    fbde_pkg::cfg_t                cfg;
    fbde_pkg::ram_wr_t             ram_wr;
    logic [fbde_pkg::ADDR_W-1:0]   ram_rd_addr;
    logic [fbde_pkg::COL_W-1:0]    ram_rd_data;

    fbde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbde_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fbde_engine u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pixel_colour     (pixel_colour),
        .reference_colour (reference_colour),
        .rect_width       (rect_width),
        .rect_height      (rect_height),
        .radius           (radius),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result_kind      (result_kind),
        .read_colour      (read_colour),
        .init_written     (init_written),
        .ram_wr           (ram_wr),
        .ram_rd_addr      (ram_rd_addr),
        .ram_rd_data      (ram_rd_data)
    );

endmodule

`default_nettype wire

>>> rtl/fbde_checker.sv
// port level checks for the framebuffer draw engine, bound to the top level
`default_nettype none

module fbde_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        result_kind,
    input wire logic [fbde_pkg::OUT_W-1:0]  read_colour,
    input wire logic                        init_written
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(read_colour) && $stable(init_written))
        else $error("result beat changed while stalled");

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in progress");

    // a result is only produced by a command in progress
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a command in progress");

    // unused result fields are zero
    a_unused_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == fbde_pkg::KIND_GET && !init_written)
            || (result_kind == fbde_pkg::KIND_INIT && read_colour == '0))
        else $error("unused result field not zero");

endmodule

bind framebuffer_draw_engine fbde_checker u_fbde_checker (.*);

`default_nettype wire

>>> tb/frame_checker.sv
`timescale 1ns / 1ps
// frame checker: mirrors the frame store and compares every reply beat with its prediction
module frame_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fbde_pkg::PADDR_W-1:0] paddr,
    input  wire logic [fbde_pkg::PDATA_W-1:0] pwdata,
    input  wire logic [fbde_pkg::PDATA_W-1:0] prdata,
    input  wire logic                         pready,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [fbde_pkg::OP_W-1:0]    op,
    input  wire logic [fbde_pkg::POS_W-1:0]   pos_x,
    input  wire logic [fbde_pkg::POS_W-1:0]   pos_y,
    input  wire logic [fbde_pkg::COL_W-1:0]   pixel_colour,
    input  wire logic [fbde_pkg::COL_W-1:0]   reference_colour,
    input  wire logic [fbde_pkg::POS_W-1:0]   rect_width,
    input  wire logic [fbde_pkg::POS_W-1:0]   rect_height,
    input  wire logic [fbde_pkg::RAD_W-1:0]   radius,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic                         result_kind,
    input  wire logic [fbde_pkg::OUT_W-1:0]   read_colour,
    input  wire logic                         init_written,
    output int                                fail_count,
    output int                                replies_pending,
    output int                                replies_checked
);
    import fbde_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [OUT_W-1:0] colour;
        logic             written;
    } pixel_reply_t;

    logic [COL_W-1:0] frame_mirror [DEPTH];
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    pixel_reply_t     replies_due [$];

    function automatic longint eff_width();
        return (width_reg > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(width_reg);
    endfunction

    function automatic longint eff_height();
        return (height_reg > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(height_reg);
    endfunction

    function automatic bit on_frame(input longint x, input longint y);
        return x >= 0 && y >= 0 && x < eff_width() && y < eff_height();
    endfunction

    function automatic int pixel_index(input longint x, input longint y);
        return int'(y * eff_width() + x);
    endfunction

    task automatic plot(input longint x, input longint y, input logic [COL_W-1:0] c);
        if (on_frame(x, y))
            frame_mirror[pixel_index(x, y)] = c;
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic apply_draw_command();
        longint       px;
        longint       py;
        longint       rw;
        longint       rh;
        longint       r;
        longint       x;
        longint       y;
        longint       x0;
        longint       x1;
        longint       y0;
        longint       y1;
        longint       dx;
        longint       dy;
        logic [COL_W-1:0] word;
        pixel_reply_t reply;
        px = pos_x;
        py = pos_y;
        rw = rect_width;
        rh = rect_height;
        r  = radius;
        reply = '0;
        case (op)
            OP_SET:
                plot(px, py, pixel_colour);
            OP_GET:
            begin
                reply.kind = KIND_GET;
                if (on_frame(px, py))
                begin
                    word = frame_mirror[pixel_index(px, py)];
                    reply.colour = word[OUT_W-1:0];
                end
                replies_due.push_back(reply);
            end
            OP_INIT:
            begin
                reply.kind = KIND_INIT;
                if (on_frame(px, py))
                begin
                    word = frame_mirror[pixel_index(px, py)];
                    if ((word & LOW24_MASK) == reference_colour)
                    begin
                        frame_mirror[pixel_index(px, py)] = pixel_colour;
                        reply.written = 1'b1;
                    end
                end
                replies_due.push_back(reply);
            end
            OP_RECT:
            begin
                x1 = (px + rw < eff_width()) ? px + rw : eff_width();
                y1 = (py + rh < eff_height()) ? py + rh : eff_height();
                for (y = py; y < y1; y++)
                    for (x = px; x < x1; x++)
                        plot(x, y, pixel_colour);
            end
            OP_CIRCLE:
            begin
                y0 = (py - r > 0) ? py - r : 0;
                y1 = (py + r < eff_height()) ? py + r : eff_height();
                x0 = (px - r > 0) ? px - r : 0;
                x1 = (px + r < eff_width()) ? px + r : eff_width();
                for (y = y0; y < y1; y++)
                    for (x = x0; x < x1; x++)
                    begin
                        dx = x - px;
                        dy = y - py;
                        if (dx * dx + dy * dy <= r * r)
                            plot(x, y, pixel_colour);
                    end
            end
            default:
                ;
        endcase
    endtask

    task automatic check_reply();
        pixel_reply_t want;
        if (replies_due.size() == 0)
        begin
            report_mismatch($sformatf("reply beat kind=%0d colour=%06h written=%0d, none due",
                                      result_kind, read_colour, init_written));
        end
        else
        begin
            want = replies_due.pop_front();
            replies_checked++;
            if (result_kind !== want.kind)
                report_mismatch($sformatf("result_kind %0d, expected %0d",
                                          result_kind, want.kind));
            if (read_colour !== want.colour)
                report_mismatch($sformatf("read_colour %06h, expected %06h",
                                          read_colour, want.colour));
            if (init_written !== want.written)
                report_mismatch($sformatf("init_written %0d, expected %0d",
                                          init_written, want.written));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame_mirror[i])
                frame_mirror[i] = '0;
            width_reg = DIM_RESET;
            height_reg = DIM_RESET;
            replies_due.delete();
            replies_pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[PADDR_W-1:2] == REG_FRAME_W)
                        width_reg = pwdata[DIM_W-1:0];
                    else
                        height_reg = pwdata[DIM_W-1:0];
                end
                else if (prdata !== {{(PDATA_W-DIM_W){1'b0}},
                                     (paddr[PADDR_W-1:2] == REG_FRAME_W) ? width_reg
                                                                          : height_reg})
                begin
                    report_mismatch($sformatf("prdata %08h at paddr %0d, expected w=%0d h=%0d",
                                              prdata, paddr, width_reg, height_reg));
                end
            end
            if (out_valid && out_ready)
                check_reply();
            if (in_valid && in_ready)
                apply_draw_command();
            replies_pending <= replies_due.size();
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, draw command stimulus, frame size phases and verdict
module tb_top;
    import fbde_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int FILL_SETTLE     = 4200;
    localparam int LONG_HOLD       = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 230;

    localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_C = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [COL_W-1:0] colour;
        logic [COL_W-1:0] ref_colour;
        logic [POS_W-1:0] w;
        logic [POS_W-1:0] h;
        logic [RAD_W-1:0] r;
    } draw_cmd_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    op = '0;
    logic [POS_W-1:0]   pos_x = '0;
    logic [POS_W-1:0]   pos_y = '0;
    logic [COL_W-1:0]   pixel_colour = '0;
    logic [COL_W-1:0]   reference_colour = '0;
    logic [POS_W-1:0]   rect_width = '0;
    logic [POS_W-1:0]   rect_height = '0;
    logic [RAD_W-1:0]   radius = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               result_kind;
    logic [OUT_W-1:0]   read_colour;
    logic               init_written;

    int fail_count;
    int replies_pending;
    int replies_checked;

    int tx_idle_pct = 20;
    int rx_idle_pct = 20;
    int hold_asks = 0;
    int hold_done = 0;
    int quiet_cycles = 0;
    int span_w = MAX_WIDTH;
    int span_h = MAX_HEIGHT;
    int pixel_ops = 0;
    int fill_ops = 0;
    int unused_ops = 0;
    logic [COL_W-1:0] palette [4];

    int phase_w [PHASES]    = '{64, 1, 127, 0, 5, 17, 64, 40};
    int phase_h [PHASES]    = '{64, 1, 100, 5, 0, 33, 1, 64};
    int phase_idle [PHASES] = '{20, 35, 10, 25, 0, 40, 15, 0};

    framebuffer_draw_engine dut (.*);
    frame_checker frame_check (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done++;
                out_ready <= 1'b1;
            end
            else if (rst_n && $urandom_range(0, 99) < rx_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic draw_cmd_t draw_cmd(input logic [OP_W-1:0] o, input int x, input int y,
                                           input logic [COL_W-1:0] colour,
                                           input logic [COL_W-1:0] ref_colour,
                                           input int w, input int h, input int r);
        draw_cmd_t c;
        c.op = o;
        c.x = POS_W'(x);
        c.y = POS_W'(y);
        c.colour = colour;
        c.ref_colour = ref_colour;
        c.w = POS_W'(w);
        c.h = POS_W'(h);
        c.r = RAD_W'(r);
        return c;
    endfunction

    function automatic logic [POS_W-1:0] pick_coord(input int span);
        int sel;
        int hot;
        sel = $urandom_range(0, 99);
        hot = (span < 8) ? span : 8;
        if (hot == 0)
            hot = 1;
        if (sel < 55)
            return POS_W'($urandom_range(0, hot - 1));
        if (sel < 88)
            return POS_W'($urandom_range(0, span + 1));
        return POS_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_extent(input int span);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 88)
            return POS_W'($urandom_range(0, 6));
        if (sel < 97)
            return POS_W'($urandom_range(0, span + 2));
        return POS_W'($urandom);
    endfunction

    function automatic draw_cmd_t random_command();
        draw_cmd_t c;
        int        sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            c.op = OP_SET;
        else if (sel < 45)
            c.op = OP_GET;
        else if (sel < 65)
            c.op = OP_INIT;
        else if (sel < 80)
            c.op = OP_RECT;
        else if (sel < 95)
            c.op = OP_CIRCLE;
        else
            c.op = OP_W'($urandom_range(OP_RESERVED_A, OP_RESERVED_C));
        c.x = pick_coord(span_w);
        c.y = pick_coord(span_h);
        c.colour = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 3)] : $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            c.ref_colour = palette[$urandom_range(0, 3)] & LOW24_MASK;
        else if (sel < 70)
            c.ref_colour = '0;
        else if (sel < 85)
            c.ref_colour = $urandom;
        else
            c.ref_colour = $urandom & LOW24_MASK;
        c.w = pick_extent(span_w);
        c.h = pick_extent(span_h);
        sel = $urandom_range(0, 99);
        if (sel < 80)
            c.r = RAD_W'($urandom_range(0, 6));
        else if (sel < 94)
            c.r = RAD_W'($urandom_range(0, 40));
        else
            c.r = RAD_W'($urandom_range(0, 4095));
        return c;
    endfunction

    task automatic send_command(input draw_cmd_t c);
        in_valid         <= 1'b1;
        op               <= c.op;
        pos_x            <= c.x;
        pos_y            <= c.y;
        pixel_colour     <= c.colour;
        reference_colour <= c.ref_colour;
        rect_width       <= c.w;
        rect_height      <= c.h;
        radius           <= c.r;
        do
            @(posedge clk);
        while (!in_ready);
        case (c.op)
            OP_SET, OP_GET, OP_INIT:
                pixel_ops++;
            OP_RECT, OP_CIRCLE:
                fill_ops++;
            default:
                unused_ops++;
        endcase
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_pending != 0);
    endtask

    task automatic apb_access(input logic idx, input logic is_write,
                              input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        draw_cmd_t c;
        draw_cmd_t opening [$];
        int        phase;
        int        k;
        foreach (palette[i])
            palette[i] = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        apb_access(REG_FRAME_W, 1'b0, '0);
        apb_access(REG_FRAME_H, 1'b0, '0);

        // opening commands assume the 64 by 64 frame left by reset
        opening.push_back(draw_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_SET, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_INIT, 0, 0, 32'h1234_5678, 32'h00FF_FFFF, 0, 0, 0));
        opening.push_back(draw_cmd(OP_INIT, 0, 0, 32'h0, 32'hFF34_5678, 0, 0, 0));
        opening.push_back(draw_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_SET, 63, 63, 32'hA5A5_A5A5, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_GET, 63, 63, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_SET, 64, 0, 32'h5A5A_5A5A, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_GET, 64, 0, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_GET, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_INIT, 0, 64, 32'h0000_0001, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_RECT, 2, 2, 32'h7777_7777, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_RECT, 60, 60, 32'h0F0F_0F0F, 0, 16'hFFFF, 16'hFFFF, 0));
        opening.push_back(draw_cmd(OP_GET, 63, 63, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_GET, 59, 60, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_CIRCLE, 10, 10, 32'h1111_1111, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_CIRCLE, 0, 0, 32'h00C0_FFEE, 0, 0, 0, 5));
        opening.push_back(draw_cmd(OP_GET, 4, 2, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_CIRCLE, 32, 32, 32'hDEAD_0BEE, 0, 0, 0, 12'hFFF));
        opening.push_back(draw_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0));
        opening.push_back(draw_cmd(OP_RESERVED_A, 1, 1, 32'hFFFF_FFFF, 0, 4, 4, 4));
        opening.push_back(draw_cmd(OP_RESERVED_B, 1, 1, 32'hFFFF_FFFF, 0, 4, 4, 4));
        opening.push_back(draw_cmd(OP_RESERVED_C, 1, 1, 32'hFFFF_FFFF, 0, 4, 4, 4));
        opening.push_back(draw_cmd(OP_GET, 1, 1, 0, 0, 0, 0, 0));
        foreach (opening[i])
        begin
            maybe_gap();
            send_command(opening[i]);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            // a fill may still be running after the last reply, let it finish
            wait_for_replies();
            repeat (FILL_SETTLE) @(posedge clk);
            apb_access(REG_FRAME_W, 1'b1, ($urandom & 32'hFFFF_FF80) | phase_w[phase]);
            apb_access(REG_FRAME_H, 1'b1, ($urandom & 32'hFFFF_FF80) | phase_h[phase]);
            apb_access(REG_FRAME_W, 1'b0, '0);
            apb_access(REG_FRAME_H, 1'b0, '0);
            span_w = (phase_w[phase] > MAX_WIDTH) ? MAX_WIDTH : phase_w[phase];
            span_h = (phase_h[phase] > MAX_HEIGHT) ? MAX_HEIGHT : phase_h[phase];
            tx_idle_pct = phase_idle[phase];
            rx_idle_pct <= phase_idle[phase];
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                c = random_command();
                // reads stack up behind a long output stall
                if (phase == 0 && k == 60)
                    hold_asks <= hold_asks + 1;
                if (phase == 0 && k >= 60 && k < 100)
                    c.op = OP_GET;
                if (phase == 2 && k == 100)
                    wait_for_replies();
                maybe_gap();
                send_command(c);
            end
        end

        wait_for_replies();
        repeat (FILL_SETTLE) @(posedge clk);
        $display("covered %0d commands (%0d pixel, %0d fill, %0d unused opcodes) over %0d sizes",
                 pixel_ops + fill_ops + unused_ops, pixel_ops, fill_ops, unused_ops, PHASES + 1);
        $display("%0d reply beats compared with the mirrored frame", replies_checked);
        if (fail_count == 0 && replies_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
